/* rtl/gbmb_pkg.sv */
// ----------------------------------------------------------------------------
// gbmb_pkg
// Shared types and codes for the block-mean grid binner.
// ----------------------------------------------------------------------------
package gbmb_pkg;

    // control sequence of the binner
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MULX,
        S_MULY,
        S_AXIS,
        S_MULIDX,
        S_READ,
        S_MODIFY,
        S_DIV,
        S_DONE
    } t_state;

    // one cell of the store
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum_x;
        logic [63:0] sum_y;
        logic [63:0] sum_z;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    // configuration register indexes
    localparam logic [2:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [2:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] CFG_X_SCALE  = 3'd2;
    localparam logic [2:0] CFG_Y_SCALE  = 3'd3;
    localparam logic [2:0] CFG_COLUMNS  = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;
    localparam logic [2:0] CFG_PIXREG   = 3'd6;

    // result status codes
    localparam logic [1:0] ST_BINNED  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // function codes
    localparam logic FN_ADD  = 1'b0;
    localparam logic FN_READ = 1'b1;

endpackage

/* rtl/gbmb_ram.sv */
// ----------------------------------------------------------------------------
// gbmb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gbmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/grid_block_mean_binner.sv */
// ----------------------------------------------------------------------------
// grid_block_mean_binner
// Bins Q16.16 points into grid cells, accumulating count and coordinate sums
// per cell; a read transaction returns a cell's truncated means and clears it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | in        | i_in_valid/o_in_stall  | func, x, y, z, cell_index
//  out     | out       | o_out_valid/i_out_stall| status, cell_res, means, count
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  An add runs two axis multiplies, the cell index multiply and one
//  read-modify-write of the cell store; a point that misses the store skips
//  the modify step. A read of an empty cell needs no divide; a read of a
//  filled cell also runs the shared 64-step bit-serial divider.
//  After reset a clearing pass writes every cell with the input stalled. A
//  stalled result is held in the output register while the next
//  transaction is accepted and worked on.
// ----------------------------------------------------------------------------
module grid_block_mean_binner #(
    parameter int CELL_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    input  logic [11:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_cell_res,
    output logic [31:0] o_mean_x,
    output logic [31:0] o_mean_y,
    output logic [31:0] o_mean_z,
    output logic [31:0] o_point_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    import gbmb_pkg::*;

    localparam int          AW       = $clog2(CELL_CAPACITY);
    localparam logic [26:0] CAP_W    = 27'(CELL_CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CELL_CAPACITY - 1);

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_x_org, r_y_org, r_x_scale, r_y_scale;
    logic [12:0] r_cols, r_rows;
    logic        r_pixreg;

    // item and mapping registers
    logic        r_func;
    logic [31:0] r_x, r_y, r_z;
    logic [32:0] r_dx, r_dy;
    logic [64:0] r_prod_x, r_prod_y;
    logic [12:0] r_i, r_jrow;
    logic        r_in_grid;
    logic [26:0] r_idx;
    logic [AW-1:0] r_clr_addr;

    // divider lanes
    logic [63:0] r_dvd [3];
    logic [32:0] r_rem [3];
    logic        r_neg [3];
    logic [31:0] r_divisor;
    logic [5:0]  r_dcnt;
    logic        r_use_div;

    // pending result and output register
    logic [1:0]  r_res_status;
    logic [11:0] r_res_cell;
    logic [31:0] r_res_cnt;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [11:0] r_cell;
    logic [31:0] r_mx, r_my, r_mz, r_cnt;

    // combinational
    logic        in_acc, out_load, bad_item;
    logic [32:0] mag_x, mag_y;
    logic [64:0] off;
    logic [65:0] sum_x, sum_y;
    logic [33:0] qx, qy;
    logic        ok_x, ok_y;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    t_cell       ram_wdata, cell_rd;
    logic [CELL_W-1:0] ram_rdata;
    logic [63:0] step_dvd [3];
    logic [32:0] step_rem [3];
    logic [63:0] sum_mag [3];
    logic [63:0] sum_in [3];
    logic [31:0] mean [3];

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cell_rd     = t_cell'(ram_rdata);

    // axis mapping: magnitude of offset, then floor with registration offset
    always_comb begin
        mag_x = r_dx[32] ? (33'd0 - r_dx) : r_dx;
        mag_y = r_dy[32] ? (33'd0 - r_dy) : r_dy;
        off   = r_pixreg ? 65'd0 : 65'h0_8000_0000;
        sum_x = 66'(r_prod_x) + 66'(off);
        sum_y = 66'(r_prod_y) + 66'(off);
        qx    = r_dx[32] ? 34'd0 : sum_x[65:32];
        qy    = r_dy[32] ? 34'd0 : sum_y[65:32];
        ok_x  = (r_dx[32] ? (r_prod_x <= off) : 1'b1) && (qx < 34'(r_cols));
        ok_y  = (r_dy[32] ? (r_prod_y <= off) : 1'b1) && (qy < 34'(r_rows));
    end

    // item cannot touch the store: outside grid or beyond capacity
    assign bad_item = (r_func == FN_READ) ? (r_idx >= CAP_W) : (!r_in_grid || r_idx >= CAP_W);

    // divider step and sign fix-up per lane
    always_comb begin
        sum_in[0] = cell_rd.sum_x;
        sum_in[1] = cell_rd.sum_y;
        sum_in[2] = cell_rd.sum_z;
        for (int k = 0; k < 3; k++) begin
            sum_mag[k] = sum_in[k][63] ? (64'd0 - sum_in[k]) : sum_in[k];
            step_rem[k] = {r_rem[k][31:0], r_dvd[k][63]};
            if (step_rem[k] >= {1'b0, r_divisor}) begin
                step_rem[k] = step_rem[k] - {1'b0, r_divisor};
                step_dvd[k] = {r_dvd[k][62:0], 1'b1};
            end else begin
                step_dvd[k] = {r_dvd[k][62:0], 1'b0};
            end
            mean[k] = !r_use_div ? 32'd0 :
                      (r_neg[k] ? (32'd0 - r_dvd[k][31:0]) : r_dvd[k][31:0]);
        end
    end

    // store access: clearing pass, or the read-modify-write of one cell
    always_comb begin
        ram_addr  = (r_state == S_CLEAR) ? r_clr_addr : r_idx[AW-1:0];
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_MODIFY) begin
            if (r_func == FN_READ) begin
                ram_we = (cell_rd.count != 32'd0);
            end else begin
                ram_we          = (cell_rd.count != 32'hFFFF_FFFF);
                ram_wdata.count = cell_rd.count + 32'd1;
                ram_wdata.sum_x = cell_rd.sum_x + {{32{r_x[31]}}, r_x};
                ram_wdata.sum_y = cell_rd.sum_y + {{32{r_y[31]}}, r_y};
                ram_wdata.sum_z = cell_rd.sum_z + {{32{r_z[31]}}, r_z};
            end
        end
    end

    gbmb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr_addr == LAST_A) n_state = S_IDLE;
            S_IDLE:   if (in_acc) n_state = (i_func == FN_READ) ? S_READ : S_MULX;
            S_MULX:   n_state = S_MULY;
            S_MULY:   n_state = S_AXIS;
            S_AXIS:   n_state = S_MULIDX;
            S_MULIDX: n_state = S_READ;
            S_READ:   n_state = bad_item ? S_DONE : S_MODIFY;
            S_MODIFY: begin
                n_state = (r_func == FN_READ && cell_rd.count != 32'd0) ? S_DIV : S_DONE;
            end
            S_DIV:    if (r_dcnt == 6'd0) n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_x_org     <= 32'd0;
            r_y_org     <= 32'd0;
            r_x_scale   <= 32'd65536;
            r_y_scale   <= 32'd65536;
            r_cols      <= 13'd64;
            r_rows      <= 13'd64;
            r_pixreg    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // hold the result until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_ORIGIN: r_x_org   <= i_cfg_data;
                    CFG_Y_ORIGIN: r_y_org   <= i_cfg_data;
                    CFG_X_SCALE:  r_x_scale <= i_cfg_data;
                    CFG_Y_SCALE:  r_y_scale <= i_cfg_data;
                    CFG_COLUMNS:  r_cols    <= i_cfg_data[12:0];
                    CFG_ROWS:     r_rows    <= i_cfg_data[12:0];
                    CFG_PIXREG:   r_pixreg  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_func <= i_func;
                    r_x    <= i_x;
                    r_y    <= i_y;
                    r_z    <= i_z;
                    r_dx   <= {i_x[31], i_x} - {r_x_org[31], r_x_org};
                    r_dy   <= {i_y[31], i_y} - {r_y_org[31], r_y_org};
                    r_idx  <= 27'(i_cell_index);
                end
            end
            S_MULX: r_prod_x <= 65'(mag_x) * 65'(r_x_scale);
            S_MULY: r_prod_y <= 65'(mag_y) * 65'(r_y_scale);
            S_AXIS: begin
                r_i       <= qx[12:0];
                r_jrow    <= r_rows - 13'd1 - qy[12:0];
                r_in_grid <= ok_x && ok_y;
            end
            S_MULIDX: r_idx <= 27'(26'(r_jrow) * 26'(r_cols)) + 27'(r_i);
            S_READ: begin
                // drop items that cannot reach the store
                r_use_div <= 1'b0;
                r_res_cnt <= 32'd0;
                if (r_func == FN_READ) begin
                    r_res_status <= ST_EMPTY;
                    r_res_cell   <= r_idx[11:0];
                end else begin
                    r_res_status <= ST_OUTSIDE;
                    r_res_cell   <= 12'd0;
                end
            end
            S_MODIFY: begin
                r_res_cell <= r_idx[11:0];
                if (r_func == FN_READ) begin
                    r_res_status <= (cell_rd.count != 32'd0) ? ST_FULL : ST_EMPTY;
                    r_res_cnt    <= cell_rd.count;
                    r_use_div    <= (cell_rd.count != 32'd0);
                    r_divisor    <= cell_rd.count;
                    r_dcnt       <= 6'd63;
                    for (int k = 0; k < 3; k++) begin
                        r_dvd[k] <= sum_mag[k];
                        r_rem[k] <= 33'd0;
                        r_neg[k] <= sum_in[k][63];
                    end
                end else if (cell_rd.count == 32'hFFFF_FFFF) begin
                    r_res_status <= ST_FULL;
                    r_res_cnt    <= cell_rd.count;
                end else begin
                    r_res_status <= ST_BINNED;
                    r_res_cnt    <= cell_rd.count + 32'd1;
                end
            end
            S_DIV: begin
                r_dcnt <= r_dcnt - 6'd1;
                for (int k = 0; k < 3; k++) begin
                    r_dvd[k] <= step_dvd[k];
                    r_rem[k] <= step_rem[k];
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_status <= r_res_status;
                    r_cell   <= r_res_cell;
                    r_cnt    <= r_res_cnt;
                    r_mx     <= mean[0];
                    r_my     <= mean[1];
                    r_mz     <= mean[2];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_cell_res    = r_cell;
    assign o_mean_x      = r_mx;
    assign o_mean_y      = r_my;
    assign o_mean_z      = r_mz;
    assign o_point_count = r_cnt;

    // store is written only by the clearing pass or a modify step
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_MODIFY))
        else $error("store written outside clear or modify");

    // one transaction at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("second transaction taken while busy");

    // a full cell is never incremented
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY && ram_we && r_func == FN_ADD)
            |-> (cell_rd.count != 32'hFFFF_FFFF))
        else $error("cell count wrapped");

    // divider finishes into the result state
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_dcnt == 6'd0) |=> (r_state == S_DONE))
        else $error("divider did not finish");

endmodule
